// File: hdl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Each macro checks a property on the rising edge of clk, off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle or sequence property with an error message on failure
`define CHECK_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

// File: hdl/ffca_pkg.sv
// Package for the first-fit timed cell allocator: sizes, codes, record types.
// Depends on nothing; used by the top level.
`default_nettype none

package ffca_pkg;

	localparam int MEM_CELLS_DEF  = 64;
	localparam int WAIT_DEPTH_DEF = 32;
	localparam int TAG_COUNT      = 26;

	typedef enum logic {
		OP_REQ  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		K_PLACED   = 3'd0,
		K_QUEUED   = 3'd1,
		K_DROPPED  = 3'd2,
		K_INVALID  = 3'd3,
		K_RELEASED = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  cell_index;
		logic [15:0] owner;
		logic [15:0] chan;
		logic [4:0]  tag;
		logic        notify;
		logic        dequeued;
		logic [15:0] dq_owner;
		logic [5:0]  dq_start;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [15:0] owner;
		logic [15:0] chan;
		logic [15:0] start;
		logic [7:0]  lease;
		logic [4:0]  tag;
	} cell_rec_t;

	typedef struct packed {
		logic [15:0] owner;
		logic [15:0] chan;
		logic [6:0]  size;
		logic [7:0]  lease;
		logic [4:0]  tag;
	} wait_rec_t;

endpackage

`default_nettype wire

// File: hdl/ffca_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the cell and wait records of the allocator.
`default_nettype none

module ffca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/first_fit_timed_cell_allocator_unit.sv
// First-fit timed cell allocator. A bad request goes straight to its result; a good one is
// scanned, then placed, queued or dropped: the first-fit scan walks one cell a cycle, placement
// one cell a cycle. A tick walks every cell: each is read, a held one is checked, a released
// one is pushed out; a released cell with a waiting head fetches it, scans and places it if it
// fits. One item at a time; a stalled result register holds the next one.
// Reset clears control state and the occupancy bits; record RAMs need no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module first_fit_timed_cell_allocator_unit
	import ffca_pkg::*;
#(
	parameter int MEM_CELLS  = MEM_CELLS_DEF,
	parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic        op,
	input  wire logic [15:0] owner_id,
	input  wire logic [15:0] reply_channel,
	input  wire logic [6:0]  request_size,
	input  wire logic [7:0]  lease_seconds,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [2:0]  kind,
	output      logic [5:0]  cell_index,
	output      logic [15:0] owner_id_res,
	output      logic [15:0] reply_channel_res,
	output      logic [4:0]  tag,
	output      logic        notify,
	output      logic        dequeued,
	output      logic [15:0] dequeued_owner,
	output      logic [5:0]  dequeued_start,
	output      logic        last
);

	localparam int IW = $clog2(MEM_CELLS);
	localparam int WW = $clog2(WAIT_DEPTH);
	localparam int CW = $clog2(WAIT_DEPTH + 1);
	localparam logic [6:0]    CELLS_W7  = 7'(MEM_CELLS);
	localparam logic [IW-1:0] LAST_CELL = IW'(MEM_CELLS - 1);
	localparam logic [WW-1:0] LAST_WPTR = WW'(WAIT_DEPTH - 1);
	localparam logic [CW-1:0] WFULL     = CW'(WAIT_DEPTH);
	localparam logic [4:0]    LAST_TAG  = 5'(TAG_COUNT - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH,
		ST_PLACE,
		ST_ENQ,
		ST_EMIT,
		ST_T_RD,
		ST_T_CHK,
		ST_T_WQ,
		ST_T_PUSH,
		ST_T_NEXT,
		ST_T_FIN
	} state_t;

	state_t            state_q;
	logic [MEM_CELLS-1:0] occ_q;
	logic [15:0]       now_q;
	logic [4:0]        next_tag_q;
	logic [15:0]       last_rel_q;
	logic [WW-1:0]     head_q;
	logic [WW-1:0]     tail_q;
	logic [CW-1:0]     wcnt_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     scan_q;
	logic [6:0]        run_q;
	logic [6:0]        len_q;
	logic              srch_tick_q;
	logic [IW-1:0]     plc_addr_q;
	logic [6:0]        plc_left_q;
	logic [15:0]       plc_owner_q;
	logic [15:0]       plc_chan_q;
	logic [7:0]        plc_lease_q;
	logic [4:0]        plc_tag_q;
	res_t              cur_q;
	res_t              pend_q;
	logic              pend_valid_q;
	res_t              out_q;
	logic              out_valid_q;

	cell_rec_t cell_wr, cell_rd;
	wait_rec_t wait_wr, wait_rd;
	logic      cell_we, wait_we;

	logic          out_free;
	logic          out_load;
	logic          scan_free, scan_found;
	logic [6:0]    run_inc;
	logic [IW-1:0] scan_start;
	logic [15:0]   elapsed;
	logic          req_bad;
	res_t          req_res, rel_res, fin_res;

	ffca_ram #(.WIDTH($bits(cell_rec_t)), .DEPTH(MEM_CELLS)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (plc_addr_q),
		.wdata (cell_wr),
		.raddr (idx_q),
		.rdata (cell_rd)
	);

	ffca_ram #(.WIDTH($bits(wait_rec_t)), .DEPTH(WAIT_DEPTH)) u_wait_ram (
		.clk   (clk),
		.we    (wait_we),
		.waddr (tail_q),
		.wdata (wait_wr),
		.raddr (head_q),
		.rdata (wait_rd)
	);

	always_comb begin
		cell_we = (state_q == ST_PLACE);
		cell_wr = '{owner: plc_owner_q, chan: plc_chan_q, start: now_q,
			lease: plc_lease_q, tag: plc_tag_q};
		wait_we = (state_q == ST_ENQ);
		wait_wr = '{owner: plc_owner_q, chan: plc_chan_q, size: len_q,
			lease: plc_lease_q, tag: plc_tag_q};
		out_free   = !out_valid_q || !out_stall;
		out_load   = out_free && ((state_q == ST_EMIT) ||
			(pend_valid_q && (state_q inside {ST_T_PUSH, ST_T_FIN})));
		scan_free  = !occ_q[scan_q];
		run_inc    = run_q + 7'd1;
		scan_found = scan_free && (run_inc == len_q);
		scan_start = IW'(8'(scan_q) + 8'd1 - {1'b0, len_q});
		elapsed    = now_q - cell_rd.start;
		req_bad    = (owner_id == 16'd0) || (request_size == 7'd0) ||
			(request_size > CELLS_W7);
		req_res       = '0;
		req_res.kind  = K_INVALID;
		req_res.owner = owner_id;
		req_res.chan  = reply_channel;
		req_res.tag   = req_bad ? 5'd0 : next_tag_q;
		req_res.last  = 1'b1;
		rel_res            = '0;
		rel_res.kind       = K_RELEASED;
		rel_res.cell_index = 6'(idx_q);
		rel_res.owner      = cell_rd.owner;
		rel_res.chan       = cell_rd.chan;
		rel_res.tag        = cell_rd.tag;
		rel_res.notify     = (cell_rd.owner != last_rel_q);
		fin_res      = pend_q;
		fin_res.last = 1'b1;
	end

	assign in_stall          = (state_q != ST_IDLE);
	assign out_valid         = out_valid_q;
	assign kind              = out_q.kind;
	assign cell_index        = out_q.cell_index;
	assign owner_id_res      = out_q.owner;
	assign reply_channel_res = out_q.chan;
	assign tag               = out_q.tag;
	assign notify            = out_q.notify;
	assign dequeued          = out_q.dequeued;
	assign dequeued_owner    = out_q.dq_owner;
	assign dequeued_start    = out_q.dq_start;
	assign last              = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			occ_q        <= '0;
			now_q        <= '0;
			next_tag_q   <= '0;
			last_rel_q   <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			wcnt_q       <= '0;
			idx_q        <= '0;
			scan_q       <= '0;
			run_q        <= '0;
			len_q        <= '0;
			srch_tick_q  <= 1'b0;
			plc_addr_q   <= '0;
			plc_left_q   <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (op == OP_REQ) begin
							cur_q       <= req_res;
							plc_owner_q <= owner_id;
							plc_chan_q  <= reply_channel;
							plc_lease_q <= lease_seconds;
							plc_tag_q   <= next_tag_q;
							len_q       <= request_size;
							scan_q      <= '0;
							run_q       <= '0;
							srch_tick_q <= 1'b0;
							if (req_bad) begin
								state_q <= ST_EMIT;
							end else begin
								next_tag_q <= (next_tag_q == LAST_TAG) ? 5'd0
									: next_tag_q + 5'd1;
								state_q    <= ST_SRCH;
							end
						end else begin
							now_q        <= now_q + 16'd1;
							idx_q        <= '0;
							pend_valid_q <= 1'b0;
							state_q      <= ST_T_RD;
						end
					end
				end
				ST_SRCH: begin
					run_q  <= scan_free ? run_inc : 7'd0;
					scan_q <= scan_q + 1'b1;
					if (scan_found) begin
						plc_addr_q <= scan_start;
						plc_left_q <= len_q;
						state_q    <= ST_PLACE;
						if (srch_tick_q) begin
							cur_q.dequeued <= 1'b1;
							cur_q.dq_owner <= plc_owner_q;
							cur_q.dq_start <= 6'(scan_start);
							head_q <= (head_q == LAST_WPTR) ? '0 : head_q + 1'b1;
							wcnt_q <= wcnt_q - 1'b1;
						end else begin
							cur_q.kind       <= K_PLACED;
							cur_q.cell_index <= 6'(scan_start);
						end
					end else if (scan_q == LAST_CELL) begin
						if (srch_tick_q) begin
							state_q <= ST_T_PUSH;
						end else if (wcnt_q == WFULL) begin
							cur_q.kind <= K_DROPPED;
							state_q    <= ST_EMIT;
						end else begin
							state_q <= ST_ENQ;
						end
					end
				end
				ST_PLACE: begin
					occ_q[plc_addr_q] <= 1'b1;
					plc_addr_q        <= plc_addr_q + 1'b1;
					plc_left_q        <= plc_left_q - 7'd1;
					if (plc_left_q == 7'd1) begin
						state_q <= srch_tick_q ? ST_T_PUSH : ST_EMIT;
					end
				end
				ST_ENQ: begin
					tail_q     <= (tail_q == LAST_WPTR) ? '0 : tail_q + 1'b1;
					wcnt_q     <= wcnt_q + 1'b1;
					cur_q.kind <= K_QUEUED;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q   <= cur_q;
						state_q <= ST_IDLE;
					end
				end
				ST_T_RD: begin
					// RAM reads idx_q now; data lands in the check state
					state_q <= occ_q[idx_q] ? ST_T_CHK : ST_T_NEXT;
				end
				ST_T_CHK: begin
					if (elapsed >= {8'd0, cell_rd.lease}) begin
						cur_q        <= rel_res;
						last_rel_q   <= cell_rd.owner;
						occ_q[idx_q] <= 1'b0;
						state_q <= (wcnt_q != '0) ? ST_T_WQ : ST_T_PUSH;
					end else begin
						state_q <= ST_T_NEXT;
					end
				end
				ST_T_WQ: begin
					plc_owner_q <= wait_rd.owner;
					plc_chan_q  <= wait_rd.chan;
					plc_lease_q <= wait_rd.lease;
					plc_tag_q   <= wait_rd.tag;
					len_q       <= wait_rd.size;
					scan_q      <= '0;
					run_q       <= '0;
					srch_tick_q <= 1'b1;
					state_q     <= ST_SRCH;
				end
				ST_T_PUSH: begin
					// hold the newest release until we know whether it is the last
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							out_q <= pend_q;
						end
						pend_q       <= cur_q;
						pend_valid_q <= 1'b1;
						state_q      <= ST_T_NEXT;
					end
				end
				ST_T_NEXT: begin
					if (idx_q == LAST_CELL) begin
						state_q <= ST_T_FIN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_T_RD;
					end
				end
				ST_T_FIN: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_q        <= fin_res;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`CHECK_PROP(a_wcnt_bound, wcnt_q <= WFULL, "wait count above depth")
	`CHECK_PROP(a_place_free, (state_q == ST_PLACE) |-> !occ_q[plc_addr_q], "placing onto a used cell")
	`CHECK_PROP(a_tick_time, (state_q == ST_IDLE && in_valid && op == OP_TICK) |=> (now_q == $past(now_q) + 16'd1), "time did not advance on tick")
	`CHECK_PROP(a_pend_idle, pend_valid_q |-> (state_q != ST_IDLE), "pending release left behind")

endmodule

`default_nettype wire

// File: test/first_fit_timed_cell_allocator_unit_test.sv
// Testbench for the first-fit timed cell allocator: a table of directed transfers, a
// wait-queue fill, then random requests and ticks, all checked against a behavioral
// allocator model. Depends on ffca_pkg and first_fit_timed_cell_allocator_unit.
`default_nettype none

module first_fit_timed_cell_allocator_unit_test;
	import ffca_pkg::*;

	localparam int CELLS = 64;
	localparam int QDEPTH = 32;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = 1'b0;
	logic [15:0] owner_id = '0;
	logic [15:0] reply_channel = '0;
	logic [6:0] request_size = '0;
	logic [7:0] lease_seconds = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] kind;
	logic [5:0] cell_index;
	logic [15:0] owner_id_res;
	logic [15:0] reply_channel_res;
	logic [4:0] tag;
	logic notify;
	logic dequeued;
	logic [15:0] dequeued_owner;
	logic [5:0] dequeued_start;
	logic last;

	first_fit_timed_cell_allocator_unit uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.op(op), .owner_id(owner_id), .reply_channel(reply_channel),
		.request_size(request_size), .lease_seconds(lease_seconds),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.cell_index(cell_index), .owner_id_res(owner_id_res),
		.reply_channel_res(reply_channel_res), .tag(tag), .notify(notify),
		.dequeued(dequeued), .dequeued_owner(dequeued_owner),
		.dequeued_start(dequeued_start), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// allocator model state
	logic [15:0] m_owner[CELLS];
	logic [15:0] m_chan[CELLS];
	logic [15:0] m_start[CELLS];
	logic [7:0] m_lease[CELLS];
	logic [4:0] m_tag[CELLS];
	wait_rec_t m_wait[QDEPTH];
	int m_head, m_tail, m_count;
	logic [15:0] m_now;
	logic [4:0] m_next_tag;
	logic [15:0] m_last_owner;

	res_t pending_results[$];
	int errors = 0;
	int idle_pct = 9;
	int stall_cycles = 0;

	function automatic bit first_fit(int len, output int at);
		int run;
		run = 0;
		at = 0;
		if (len == 0 || len > CELLS) return 0;
		for (int i = 0; i < CELLS; i++) begin
			if (m_owner[i] == 0) begin
				run++;
				if (run == len) begin
					at = i + 1 - len;
					return 1;
				end
			end else run = 0;
		end
		return 0;
	endfunction

	function automatic void occupy(int at, int len, logic [15:0] o, logic [15:0] c,
			logic [7:0] l, logic [4:0] t);
		for (int i = at; i < at + len && i < CELLS; i++) begin
			m_owner[i] = o;
			m_chan[i] = c;
			m_start[i] = m_now;
			m_lease[i] = l;
			m_tag[i] = t;
		end
	endfunction

	function automatic void predict_allocation(op_t o, logic [15:0] own, logic [15:0] ch,
			logic [6:0] sz, logic [7:0] ls);
		res_t r;
		int at;
		int n;
		logic [15:0] co;
		logic [15:0] elapsed;
		if (o == OP_REQ) begin
			r = '0;
			r.owner = own;
			r.chan = ch;
			r.last = 1'b1;
			if (own == 0 || sz == 0 || sz > CELLS) begin
				r.kind = K_INVALID;
				pending_results.push_back(r);
				return;
			end
			r.tag = m_next_tag;
			if (first_fit(sz, at)) begin
				occupy(at, sz, own, ch, ls, m_next_tag);
				r.kind = K_PLACED;
				r.cell_index = at[5:0];
			end else if (m_count >= QDEPTH) begin
				r.kind = K_DROPPED;
			end else begin
				m_wait[m_tail] = '{owner: own, chan: ch, size: sz, lease: ls, tag: m_next_tag};
				m_tail = (m_tail + 1) % QDEPTH;
				m_count++;
				r.kind = K_QUEUED;
			end
			m_next_tag = (m_next_tag == TAG_COUNT - 1) ? 5'd0 : m_next_tag + 5'd1;
			pending_results.push_back(r);
			return;
		end
		m_now = m_now + 16'd1;
		n = 0;
		for (int i = 0; i < CELLS; i++) begin
			co = m_owner[i];
			if (co == 0) continue;
			elapsed = m_now - m_start[i];
			if (elapsed < m_lease[i]) continue;
			r = '0;
			r.kind = K_RELEASED;
			r.cell_index = i[5:0];
			r.owner = co;
			r.chan = m_chan[i];
			r.tag = m_tag[i];
			r.notify = (co != m_last_owner);
			m_last_owner = co;
			m_owner[i] = 0;
			if (m_count > 0 && first_fit(m_wait[m_head].size, at)) begin
				occupy(at, m_wait[m_head].size, m_wait[m_head].owner,
					m_wait[m_head].chan, m_wait[m_head].lease, m_wait[m_head].tag);
				r.dequeued = 1'b1;
				r.dq_owner = m_wait[m_head].owner;
				r.dq_start = at[5:0];
				m_head = (m_head + 1) % QDEPTH;
				m_count--;
			end
			pending_results.push_back(r);
			n++;
		end
		if (n > 0) pending_results[pending_results.size() - 1].last = 1'b1;
	endfunction

	// result side: check every transfer against the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result kind=%0d cell=%0d", $realtime, kind,
						cell_index);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (want.kind !== kind || want.cell_index !== cell_index
							|| want.owner !== owner_id_res || want.chan !== reply_channel_res
							|| want.tag !== tag || want.notify !== notify
							|| want.dequeued !== dequeued || want.dq_owner !== dequeued_owner
							|| want.dq_start !== dequeued_start || want.last !== last) begin
						$display("%0t: mismatch expected k=%0d c=%0d o=%h ch=%h t=%0d n=%b d=%b do=%h ds=%0d l=%b",
							$realtime, want.kind, want.cell_index, want.owner, want.chan,
							want.tag, want.notify, want.dequeued, want.dq_owner,
							want.dq_start, want.last);
						$display("%0t:   actual   k=%0d c=%0d o=%h ch=%h t=%0d n=%b d=%b do=%h ds=%0d l=%b",
							$realtime, kind, cell_index, owner_id_res, reply_channel_res, tag,
							notify, dequeued, dequeued_owner, dequeued_start, last);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	typedef struct {
		op_t o;
		logic [15:0] own;
		logic [15:0] ch;
		logic [6:0] sz;
		logic [7:0] ls;
		bit known;
		kind_t k;
	} stim_row_t;

	// drive one transfer; valid stays high across back-to-back items
	task automatic send_item(op_t o, logic [15:0] own, logic [15:0] ch, logic [6:0] sz,
			logic [7:0] ls);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		owner_id <= own;
		reply_channel <= ch;
		request_size <= sz;
		lease_seconds <= ls;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_allocation(o, own, ch, sz, ls);
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	stim_row_t directed_rows[$];
	int kind_at_row;
	int draw;
	logic [15:0] rnd_owner;

	initial begin
		for (int i = 0; i < CELLS; i++) m_owner[i] = 0;
		m_head = 0; m_tail = 0; m_count = 0;
		m_now = 0; m_next_tag = 0; m_last_owner = 0;

		directed_rows = '{
			'{OP_REQ, 16'h0000, 16'h1111, 7'd4, 8'd3, 1, K_INVALID},
			'{OP_REQ, 16'h0001, 16'h2222, 7'd0, 8'd3, 1, K_INVALID},
			'{OP_REQ, 16'h0002, 16'h3333, 7'd65, 8'd3, 1, K_INVALID},
			'{OP_REQ, 16'hFFFF, 16'hFFFF, 7'd127, 8'hFF, 1, K_INVALID},
			'{OP_TICK, 16'h0000, 16'h0000, 7'd0, 8'd0, 0, K_PLACED},
			'{OP_REQ, 16'hFFFF, 16'hFFFF, 7'd64, 8'd1, 1, K_PLACED},
			'{OP_REQ, 16'h0005, 16'h0050, 7'd1, 8'd0, 1, K_QUEUED},
			'{OP_REQ, 16'h0006, 16'h0060, 7'd2, 8'd0, 1, K_QUEUED},
			'{OP_TICK, 16'h0000, 16'h0000, 7'd0, 8'd0, 0, K_PLACED},
			'{OP_REQ, 16'h0007, 16'h0070, 7'd3, 8'd0, 0, K_PLACED},
			'{OP_REQ, 16'h0008, 16'h0080, 7'd1, 8'hFF, 0, K_PLACED},
			'{OP_REQ, 16'h0007, 16'h0071, 7'd5, 8'd2, 0, K_PLACED},
			'{OP_TICK, 16'h0000, 16'h0000, 7'd0, 8'd0, 0, K_PLACED},
			'{OP_TICK, 16'h0000, 16'h0000, 7'd0, 8'd0, 0, K_PLACED},
			'{OP_TICK, 16'hFFFF, 16'hFFFF, 7'd127, 8'hFF, 0, K_PLACED},
			'{OP_REQ, 16'h0001, 16'h0000, 7'd63, 8'd0, 0, K_PLACED},
			'{OP_TICK, 16'h0000, 16'h0000, 7'd0, 8'd0, 0, K_PLACED}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].o, directed_rows[i].own, directed_rows[i].ch,
				directed_rows[i].sz, directed_rows[i].ls);
			// a request leaves exactly one expectation, the newest one
			kind_at_row = pending_results.size() - 1;
			if (directed_rows[i].known && pending_results[kind_at_row].kind != directed_rows[i].k)
				begin
				$display("%0t: table row %0d expected kind %0d, model gives %0d", $realtime, i,
					directed_rows[i].k, pending_results[kind_at_row].kind);
				errors++;
			end
		end

		// load the wait queue: a whole-memory request with a long lease, then small requests
		send_item(OP_REQ, 16'h00AA, 16'h0A0A, 7'd64, 8'd40);
		for (int i = 0; i < QDEPTH + 3; i++)
			send_item(OP_REQ, 16'h0100 + i, 16'h0200 + i, 7'($urandom_range(1, 8)), 8'd1);

		// hold off until everything drains
		drop_valid();
		while (pending_results.size() != 0) @(posedge clk);

		for (int n = 0; n < 380; n++) begin
			// a quiet stretch with no idling in the middle
			idle_pct = (n >= 150 && n < 250) ? 0 : 9;
			if (n == 300) begin
				drop_valid();
				while (pending_results.size() != 0) @(posedge clk);
			end
			draw = $urandom_range(99);
			rnd_owner = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
			if (draw < 35)
				send_item(OP_TICK, 16'($urandom), 16'($urandom), 7'($urandom), 8'($urandom));
			else if (draw < 40)
				send_item(OP_REQ, ($urandom_range(1) ? 16'd0 : rnd_owner), 16'($urandom),
					7'($urandom), 8'($urandom));
			else if (draw < 45)
				send_item(OP_REQ, rnd_owner, 16'($urandom), 7'($urandom_range(33, 64)),
					8'($urandom));
			else
				send_item(OP_REQ, (rnd_owner == 0) ? 16'd1 : rnd_owner, 16'($urandom),
					7'($urandom_range(1, 12)),
					($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
		end
		drop_valid();

		while (pending_results.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: first_fit_timed_cell_allocator_unit.f
+incdir+hdl
hdl/ffca_pkg.sv
hdl/ffca_ram.sv
hdl/first_fit_timed_cell_allocator_unit.sv
test/first_fit_timed_cell_allocator_unit_test.sv
